[hdl/ecpm_pkg.sv]
package ecpm_pkg;

  // Depth of the power history ring and field widths.
  localparam int HIST_DEPTH = 16;
  localparam int POS_W      = $clog2(HIST_DEPTH);
  localparam int WIN_W      = 5;
  localparam int CNT_W      = 40;
  localparam int TIME_W     = 64;
  localparam int MW_W       = 24;
  localparam int SUM_W      = 28;
  localparam int ACC_W      = 56;
  localparam int NUM_W      = 60;
  localparam int QUOT_W     = MW_W + 1;
  localparam int CFG_DW     = 64;
  localparam int CFG_AW     = 5;

  // Scale from microjoules per nanosecond to milliwatts.
  localparam logic [19:0] MW_SCALE = 20'd1000000;
  localparam logic [MW_W-1:0] MW_MAX = {MW_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX_RST = 40'd262143328850;
  localparam logic [WIN_W-1:0] WIN_RST = 5'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_PKG_MAX  = 2'd0;
  localparam logic [1:0] REG_DRAM_MAX = 2'd1;
  localparam logic [1:0] REG_WINDOW   = 2'd2;

  // Command codes.
  localparam logic CMD_PRIME  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Divider control and status.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Wrap-aware counter difference; zero when the previous reading exceeds the maximum plus the current one.
  function automatic logic [CNT_W-1:0] wrap_delta(input logic [CNT_W-1:0] cur,
                                                  input logic [CNT_W-1:0] prev,
                                                  input logic [CNT_W-1:0] maxv);
    logic [CNT_W:0] up;
    logic [CNT_W:0] diff;
    up   = {1'b0, maxv} + {1'b0, cur};
    diff = up - {1'b0, prev};
    if (cur >= prev) begin
      return cur - prev;
    end else if (up < {1'b0, prev}) begin
      return '0;
    end else begin
      return diff[CNT_W-1:0];
    end
  endfunction

endpackage

[hdl/ecpm_div.sv]
module ecpm_div
  import ecpm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  div_ctl_t                ctl,
  input  logic [NUM_W-1:0]        dividend,
  input  logic [TIME_W-1:0]       divisor,
  output div_stat_t               stat,
  output logic [MW_W-1:0]         quot
);

  logic                 busy_r;
  logic                 done_r;
  logic [4:0]           cnt_r;
  logic [TIME_W-1:0]    rem_r;
  logic [TIME_W-1:0]    dsr_r;
  logic [QUOT_W-1:0]    low_r;
  logic [QUOT_W-1:0]    q_r;
  logic                 sat_r;
  logic [TIME_W:0]      trial;
  logic [TIME_W:0]      diff;
  logic                 take;
  logic [NUM_W-QUOT_W-1:0] hi;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign hi    = dividend[NUM_W-1:QUOT_W];
  assign trial = {rem_r, low_r[QUOT_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign take  = (trial >= {1'b0, dsr_r});

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd1);
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(QUOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath; a quotient past the upper bits saturates.
  always_ff @(posedge clk) begin
    if (ctl.start && !busy_r) begin
      rem_r <= {{(TIME_W-NUM_W+QUOT_W){1'b0}}, hi};
      dsr_r <= divisor;
      low_r <= dividend[QUOT_W-1:0];
      q_r   <= '0;
      sat_r <= ({{(TIME_W-NUM_W+QUOT_W){1'b0}}, hi} >= divisor);
    end else if (busy_r) begin
      rem_r <= take ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      low_r <= {low_r[QUOT_W-2:0], 1'b0};
      q_r   <= {q_r[QUOT_W-2:0], take};
    end
  end

  assign quot = (sat_r || q_r[QUOT_W-1]) ? MW_MAX : q_r[MW_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && $past(cnt_r) == 5'd1)
    else $error("divider done without a final step");

endmodule

[hdl/energy_counter_power_monitor_core.sv]
// Channel  | Handshake                      | Payload
// input    | in_valid / in_ready            | in_command, in_package_counter, in_dram_counter,
//          |                                | in_timestamp_ns
// result   | out_valid / out_ready          | out_* deltas, powers, averages, totals
// config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata (64-bit registers at 8*i)
// A prime, or a first sample, only sets the baseline; a zero interval returns to idle without a result.
// For a sample the shared 25-step divider runs four times,
// twice for power and twice for the moving averages.
// Reset (rst_n, synchronous) clears the baseline, ring state and totals.
// A finished result waits in the output register while the next transaction is accepted;
// the block holds in its final state only while that register is full and out_ready is low.
module energy_counter_power_monitor_core
  import ecpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [CNT_W-1:0]    in_package_counter,
  input  logic [CNT_W-1:0]    in_dram_counter,
  input  logic [TIME_W-1:0]   in_timestamp_ns,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CNT_W-1:0]    out_package_delta_uj,
  output logic [CNT_W-1:0]    out_dram_delta_uj,
  output logic [TIME_W-1:0]   out_interval_ns,
  output logic [MW_W-1:0]     out_package_mw,
  output logic [MW_W-1:0]     out_dram_mw,
  output logic [MW_W:0]       out_total_mw,
  output logic [MW_W-1:0]     out_package_smooth_mw,
  output logic [MW_W-1:0]     out_dram_smooth_mw,
  output logic [MW_W:0]       out_total_smooth_mw,
  output logic [ACC_W-1:0]    out_package_energy_total_uj,
  output logic [ACC_W-1:0]    out_dram_energy_total_uj,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DELTA = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_START = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_RING  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   pkg_max_r, dram_max_r;
  logic [WIN_W-1:0]   win_r;
  logic               base_valid_r;
  logic [CNT_W-1:0]   last_pc_r, last_dc_r;
  logic [TIME_W-1:0]  last_t_r;
  logic [CNT_W-1:0]   pc_r, dc_r;
  logic [TIME_W-1:0]  t_r;
  logic [TIME_W-1:0]  dt_r;
  logic [CNT_W-1:0]   pd_r, dd_r;
  logic [NUM_W-1:0]   num_r;
  logic [1:0]         phase_r;
  logic [MW_W-1:0]    pmw_r, dmw_r, ps_r;
  logic [SUM_W-1:0]   psum_r, dsum_r;
  logic [WIN_W-1:0]   fill_r;
  logic [POS_W-1:0]   pos_r;
  logic [ACC_W-1:0]   pacc_r, dacc_r;
  logic               out_valid_r;
  logic [MW_W-1:0]    pring_r [HIST_DEPTH];
  logic [MW_W-1:0]    dring_r [HIST_DEPTH];

  logic               in_acc, prime, cfg_wr, out_free;
  logic [1:0]         cfg_idx;
  logic [TIME_W-1:0]  dt;
  logic [WIN_W-1:0]   w;
  logic [POS_W-1:0]   posx;
  logic [WIN_W-1:0]   pos_inc;
  logic               full;
  logic [CNT_W-1:0]   mul_src;
  logic [NUM_W-1:0]   dvd;
  logic [TIME_W-1:0]  dsr;
  logic [MW_W-1:0]    quot;
  div_ctl_t           dctl;
  div_stat_t          dstat;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign prime    = (in_command == CMD_PRIME) || !base_valid_r;
  assign out_free = !out_valid_r || out_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = paddr[CFG_AW-1:3];
  assign pready   = 1'b1;
  assign dt       = t_r - last_t_r;

  // Register read mux.
  always_comb begin
    unique case (cfg_idx)
      REG_PKG_MAX:  prdata = {{(CFG_DW-CNT_W){1'b0}}, pkg_max_r};
      REG_DRAM_MAX: prdata = {{(CFG_DW-CNT_W){1'b0}}, dram_max_r};
      REG_WINDOW:   prdata = {{(CFG_DW-WIN_W){1'b0}}, win_r};
      default:      prdata = '0;
    endcase
  end

  // Effective window and ring position.
  always_comb begin
    priority if (win_r == '0) begin
      w = WIN_W'(1);
    end else if (win_r > WIN_W'(HIST_DEPTH)) begin
      w = WIN_W'(HIST_DEPTH);
    end else begin
      w = win_r;
    end
    posx    = ({1'b0, pos_r} >= w) ? '0 : pos_r;
    pos_inc = {1'b0, posx} + WIN_W'(1);
    full    = (fill_r >= w);
  end

  // Shared divider operands: power first, then ring averages.
  assign mul_src  = (phase_r == 2'd0) ? pd_r : dd_r;
  assign dvd      = phase_r[1] ? {{(NUM_W-SUM_W){1'b0}}, (phase_r[0] ? dsum_r : psum_r)} : num_r;
  assign dsr      = phase_r[1] ? {{(TIME_W-WIN_W){1'b0}}, fill_r} : dt_r;
  assign dctl.start = (state_r == S_START);

  ecpm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dctl),
    .dividend (dvd),
    .divisor  (dsr),
    .stat     (dstat),
    .quot     (quot)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && !prime) state_nxt = S_DELTA;
      S_DELTA: state_nxt = (dt == '0) ? S_IDLE : S_MUL;
      S_MUL:   state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV: begin
        if (dstat.done) begin
          unique case (phase_r)
            2'd0:    state_nxt = S_MUL;
            2'd1:    state_nxt = S_RING;
            2'd2:    state_nxt = S_START;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RING:  state_nxt = S_START;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration, baseline, ring bookkeeping and totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pkg_max_r    <= CNT_MAX_RST;
      dram_max_r   <= CNT_MAX_RST;
      win_r        <= WIN_RST;
      base_valid_r <= 1'b0;
      last_pc_r    <= '0;
      last_dc_r    <= '0;
      last_t_r     <= '0;
      psum_r       <= '0;
      dsum_r       <= '0;
      fill_r       <= '0;
      pos_r        <= '0;
      pacc_r       <= '0;
      dacc_r       <= '0;
      phase_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_PKG_MAX:  pkg_max_r  <= pwdata[CNT_W-1:0];
          REG_DRAM_MAX: dram_max_r <= pwdata[CNT_W-1:0];
          REG_WINDOW: begin
            win_r  <= pwdata[WIN_W-1:0];
            psum_r <= '0;
            dsum_r <= '0;
            fill_r <= '0;
            pos_r  <= '0;
          end
          default: ;
        endcase
      end
      if (in_acc && prime) begin
        last_pc_r    <= in_package_counter;
        last_dc_r    <= in_dram_counter;
        last_t_r     <= in_timestamp_ns;
        base_valid_r <= 1'b1;
      end
      if (state_r == S_DELTA) phase_r <= 2'd0;
      if (state_r == S_DIV && dstat.done) phase_r <= phase_r + 2'd1;
      if (state_r == S_RING) begin
        psum_r  <= full ? psum_r - SUM_W'(pring_r[posx]) + SUM_W'(pmw_r)
                        : psum_r + SUM_W'(pmw_r);
        dsum_r  <= full ? dsum_r - SUM_W'(dring_r[posx]) + SUM_W'(dmw_r)
                        : dsum_r + SUM_W'(dmw_r);
        fill_r  <= full ? w : fill_r + WIN_W'(1);
        pos_r   <= (pos_inc >= w) ? '0 : pos_inc[POS_W-1:0];
        phase_r <= 2'd2;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
        pacc_r      <= pacc_r + ACC_W'(pd_r);
        dacc_r      <= dacc_r + ACC_W'(dd_r);
        last_pc_r   <= pc_r;
        last_dc_r   <= dc_r;
        last_t_r    <= t_r;
      end
    end
  end

  // Payload registers and the power history ring.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pc_r <= in_package_counter;
      dc_r <= in_dram_counter;
      t_r  <= in_timestamp_ns;
    end
    if (state_r == S_DELTA) begin
      dt_r <= dt;
      pd_r <= wrap_delta(pc_r, last_pc_r, pkg_max_r);
      dd_r <= wrap_delta(dc_r, last_dc_r, dram_max_r);
    end
    if (state_r == S_MUL) begin
      num_r <= {{(NUM_W-CNT_W){1'b0}}, mul_src} * {{(NUM_W-20){1'b0}}, MW_SCALE};
    end
    if (state_r == S_DIV && dstat.done) begin
      unique case (phase_r)
        2'd0:    pmw_r <= quot;
        2'd1:    dmw_r <= quot;
        2'd2:    ps_r  <= quot;
        default: ;
      endcase
    end
    if (state_r == S_RING) begin
      pring_r[posx] <= pmw_r;
      dring_r[posx] <= dmw_r;
    end
    if (state_r == S_DONE && out_free) begin
      out_package_delta_uj        <= pd_r;
      out_dram_delta_uj           <= dd_r;
      out_interval_ns             <= dt_r;
      out_package_mw              <= pmw_r;
      out_dram_mw                 <= dmw_r;
      out_total_mw                <= {1'b0, pmw_r} + {1'b0, dmw_r};
      out_package_smooth_mw       <= ps_r;
      out_dram_smooth_mw          <= quot;
      out_total_smooth_mw         <= {1'b0, ps_r} + {1'b0, quot};
      out_package_energy_total_uj <= pacc_r + ACC_W'(pd_r);
      out_dram_energy_total_uj    <= dacc_r + ACC_W'(dd_r);
    end
  end

  assign out_valid = out_valid_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WIN_W'(HIST_DEPTH))
    else $error("ring fill beyond history depth");
  a_prime_base: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && prime |=> base_valid_r && state_r == S_IDLE)
    else $error("prime did not set the baseline");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the final state");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dctl.start |-> !dstat.busy)
    else $error("divider started while busy");

endmodule
